>>> design/lsn_pkg.sv
// Shared types, constants and helpers of the landmark shape normalizer.
// Depends on nothing; lsn_ctrl, lsn_datapath and the top module refer to it by scoped names.
package lsn_pkg;

    // Default shape size and fixed anchor positions
    localparam int NUM_POINTS_DEF = 20;
    localparam int ANCHOR_A       = 0;
    localparam int ANCHOR_B       = 6;

    // Field widths
    localparam int COORD_W = 16;
    localparam int POINT_W = 2 * COORD_W;
    localparam int FRAC_BITS = 12;

    // Arithmetic widths
    localparam int Q_W     = 18;               // q = 2p - p0 - p6
    localparam int PROD_W  = 2 * Q_W;          // one signed product
    localparam int ACC_W   = PROD_W + 1;       // dot / cross product accumulator
    localparam int MAG_W   = PROD_W;           // magnitude of the accumulator
    localparam int DEN_W   = 33;               // |D|^2 <= 2 * 65535^2
    localparam int QUO_W   = 16;               // quotient bits after the overflow check
    localparam int REM_W   = MAG_W + FRAC_BITS + 1;
    localparam int STEP_W  = $clog2(QUO_W + 1);

    localparam logic [COORD_W-1:0] Q_POS_MAX = 16'h7FFF;
    localparam logic [COORD_W-1:0] Q_NEG_MAX = 16'h8000;

    // Controller states
    typedef enum logic [3:0] {
        S_LOAD,
        S_DEN0,
        S_DEN1,
        S_READ,
        S_QCALC,
        S_MX0,
        S_MX1,
        S_MY0,
        S_MY1,
        S_PREP,
        S_DIV,
        S_EMIT
    } t_state;

    // Operation of the shared multiply-accumulate unit
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DEN0,
        MUL_DEN1,
        MUL_X0,
        MUL_X1,
        MUL_Y0,
        MUL_Y1
    } t_mul_op;

    // Controller to datapath
    typedef struct packed {
        logic    accept_en;
        logic    rd_issue;
        logic    q_calc;
        t_mul_op mul_op;
        logic    prep;
        logic    div_step;
        logic    emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic load_last;
        logic degen;
        logic div_done;
        logic out_free;
        logic idx_last;
    } t_dp_stat;

    // Round-to-nearest quotient into saturated signed Q4.12
    function automatic logic [COORD_W-1:0] sat_q412(
        input logic             neg,
        input logic             ovf,
        input logic [QUO_W-1:0] quo
    );
        logic [COORD_W-1:0] res;
        if (ovf) begin
            res = neg ? Q_NEG_MAX : Q_POS_MAX;
        end else if (neg) begin
            res = (quo > Q_NEG_MAX) ? Q_NEG_MAX : COORD_W'(-quo);
        end else begin
            res = (quo > Q_POS_MAX) ? Q_POS_MAX : quo;
        end
        return res;
    endfunction

endpackage

>>> design/lsn_if.sv
// Valid/ready channel interfaces of the landmark shape normalizer.
// Depends on nothing.
interface lsn_point_if;
    logic        valid;
    logic        ready;
    logic [15:0] point_x;
    logic [15:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface lsn_norm_if;
    logic        valid;
    logic        ready;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic        is_last;
    logic        degenerate;

    modport source (output valid, output norm_x, output norm_y, output is_last,
                    output degenerate, input ready);
    modport sink   (input valid, input norm_x, input norm_y, input is_last,
                    input degenerate, output ready);
endinterface

>>> design/lsn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lsn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/lsn_ctrl.sv
// Sequencer of the landmark shape normalizer: load, |D|^2, then per point read,
// multiply-accumulate, divide and emit (read and emit only when degenerate). Depends on lsn_pkg.
module lsn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsn_pkg::t_dp_stat i_stat,
    output lsn_pkg::t_dp_cmd  o_cmd
);
    lsn_pkg::t_state r_state;
    lsn_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsn_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsn_pkg::S_LOAD:  if (i_stat.load_last) n_state = lsn_pkg::S_DEN0;
            lsn_pkg::S_DEN0:  n_state = lsn_pkg::S_DEN1;
            lsn_pkg::S_DEN1:  n_state = lsn_pkg::S_READ;
            lsn_pkg::S_READ:  n_state = lsn_pkg::S_QCALC;
            lsn_pkg::S_QCALC: n_state = i_stat.degen ? lsn_pkg::S_EMIT : lsn_pkg::S_MX0;
            lsn_pkg::S_MX0:   n_state = lsn_pkg::S_MX1;
            lsn_pkg::S_MX1:   n_state = lsn_pkg::S_MY0;
            lsn_pkg::S_MY0:   n_state = lsn_pkg::S_MY1;
            lsn_pkg::S_MY1:   n_state = lsn_pkg::S_PREP;
            lsn_pkg::S_PREP:  n_state = lsn_pkg::S_DIV;
            lsn_pkg::S_DIV:   if (i_stat.div_done) n_state = lsn_pkg::S_EMIT;
            lsn_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.idx_last ? lsn_pkg::S_LOAD : lsn_pkg::S_READ;
                end
            end
            default:          n_state = lsn_pkg::S_LOAD;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.mul_op = lsn_pkg::MUL_NONE;
        case (r_state)
            lsn_pkg::S_LOAD:  o_cmd.accept_en = 1'b1;
            lsn_pkg::S_DEN0:  o_cmd.mul_op = lsn_pkg::MUL_DEN0;
            lsn_pkg::S_DEN1:  o_cmd.mul_op = lsn_pkg::MUL_DEN1;
            lsn_pkg::S_READ:  o_cmd.rd_issue = 1'b1;
            lsn_pkg::S_QCALC: o_cmd.q_calc = 1'b1;
            lsn_pkg::S_MX0:   o_cmd.mul_op = lsn_pkg::MUL_X0;
            lsn_pkg::S_MX1:   o_cmd.mul_op = lsn_pkg::MUL_X1;
            lsn_pkg::S_MY0:   o_cmd.mul_op = lsn_pkg::MUL_Y0;
            lsn_pkg::S_MY1:   o_cmd.mul_op = lsn_pkg::MUL_Y1;
            lsn_pkg::S_PREP:  o_cmd.prep = 1'b1;
            lsn_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            lsn_pkg::S_EMIT:  o_cmd.emit = 1'b1;
            default:          o_cmd = '0;
        endcase
    end

    // Input is taken only between shapes
    a_accept_only_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept_en |-> (r_state == lsn_pkg::S_LOAD))
        else $error("input enabled outside load phase");

    // A completed shape always starts the |D|^2 computation
    a_last_to_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsn_pkg::S_LOAD && i_stat.load_last) |=> (r_state == lsn_pkg::S_DEN0))
        else $error("shape end did not start normalization");

    // Emit leaves only when the output register can take the item
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsn_pkg::S_EMIT && !i_stat.out_free) |=> (r_state == lsn_pkg::S_EMIT))
        else $error("emit state left while output stalled");
endmodule

>>> design/lsn_datapath.sv
// Datapath of the landmark shape normalizer: point store, anchors, shared
// multiply-accumulate, two restoring dividers and the output register.
// Depends on lsn_pkg, lsn_if and lsn_ram.
module lsn_datapath #(
    parameter int NUM_POINTS = lsn_pkg::NUM_POINTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lsn_point_if.sink         i_point,
    lsn_norm_if.source        o_norm,
    input  lsn_pkg::t_dp_cmd  i_cmd,
    output lsn_pkg::t_dp_stat o_stat
);
    localparam int AW = $clog2(NUM_POINTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_POINTS - 1);
    localparam logic [AW-1:0] IDX_A    = AW'(lsn_pkg::ANCHOR_A);
    localparam logic [AW-1:0] IDX_B    = AW'(lsn_pkg::ANCHOR_B);
    localparam logic [lsn_pkg::STEP_W-1:0] STEP_LAST = lsn_pkg::STEP_W'(lsn_pkg::QUO_W);

    // Counters
    logic [AW-1:0] r_load_cnt;
    logic [AW-1:0] r_idx;
    logic          in_acc;
    logic          out_free;

    // Anchors and per-point terms
    logic signed [15:0]                  r_ax, r_ay, r_bx, r_by;
    logic signed [16:0]                  dx, dy;
    logic signed [lsn_pkg::Q_W-1:0]      dx_q, dy_q;
    logic signed [lsn_pkg::Q_W-1:0]      r_qx, r_qy;
    logic [lsn_pkg::POINT_W-1:0]         rd_data;
    logic signed [15:0]                  pxr, pyr;
    logic signed [lsn_pkg::Q_W-1:0]      ax_q, ay_q, bx_q, by_q;

    // Multiply-accumulate
    logic signed [lsn_pkg::Q_W-1:0]      mul_a, mul_b;
    logic signed [lsn_pkg::PROD_W-1:0]   prod;
    logic signed [lsn_pkg::ACC_W-1:0]    prod_ext;
    logic signed [lsn_pkg::ACC_W-1:0]    r_nx, r_ny;
    logic [lsn_pkg::DEN_W-1:0]           r_den;

    // Dividers
    logic [lsn_pkg::MAG_W-1:0]           mag_x, mag_y;
    logic [lsn_pkg::REM_W-1:0]           r_rx, r_ry, r_dv;
    logic [lsn_pkg::QUO_W-1:0]           r_quo_x, r_quo_y;
    logic                                r_neg_x, r_neg_y, r_ovf_x, r_ovf_y;
    logic [lsn_pkg::STEP_W-1:0]          r_step;
    logic                                ge_x, ge_y;

    // Output register
    logic        r_out_valid;
    logic [15:0] r_out_x, r_out_y;
    logic        r_out_last, r_out_degen;
    logic        degen;

    assign in_acc          = i_point.valid & i_cmd.accept_en;
    assign i_point.ready   = i_cmd.accept_en;
    assign out_free        = !r_out_valid || o_norm.ready;
    assign degen           = (r_den == '0);

    // Point store
    lsn_ram #(
        .WIDTH (lsn_pkg::POINT_W),
        .DEPTH (NUM_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_load_cnt),
        .i_wdata ({i_point.point_y, i_point.point_x}),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // Load counter and index of the point being emitted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_idx      <= '0;
        end else begin
            if (in_acc) begin
                r_load_cnt <= (r_load_cnt == LAST_IDX) ? '0 : r_load_cnt + 1'b1;
            end
            if (i_cmd.emit && out_free) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
        end
    end

    // Anchor capture while loading
    always_ff @(posedge i_clk) begin
        if (in_acc && r_load_cnt == IDX_A) begin
            r_ax <= i_point.point_x;
            r_ay <= i_point.point_y;
        end
        if (in_acc && r_load_cnt == IDX_B) begin
            r_bx <= i_point.point_x;
            r_by <= i_point.point_y;
        end
    end

    assign dx   = 17'(r_bx) - 17'(r_ax);
    assign dy   = 17'(r_by) - 17'(r_ay);
    assign dx_q = lsn_pkg::Q_W'(dx);
    assign dy_q = lsn_pkg::Q_W'(dy);

    // q = 2p - p0 - p6 from the point read out of the store
    assign pxr  = rd_data[15:0];
    assign pyr  = rd_data[31:16];
    assign ax_q = lsn_pkg::Q_W'(r_ax);
    assign ay_q = lsn_pkg::Q_W'(r_ay);
    assign bx_q = lsn_pkg::Q_W'(r_bx);
    assign by_q = lsn_pkg::Q_W'(r_by);

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_calc) begin
            r_qx <= {pxr[15], pxr, 1'b0} - ax_q - bx_q;
            r_qy <= {pyr[15], pyr, 1'b0} - ay_q - by_q;
        end
    end

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_op)
            lsn_pkg::MUL_DEN0: begin mul_a = dx_q; mul_b = dx_q; end
            lsn_pkg::MUL_DEN1: begin mul_a = dy_q; mul_b = dy_q; end
            lsn_pkg::MUL_X0:   begin mul_a = dx_q; mul_b = r_qx; end
            lsn_pkg::MUL_X1:   begin mul_a = dy_q; mul_b = r_qy; end
            lsn_pkg::MUL_Y0:   begin mul_a = dx_q; mul_b = r_qy; end
            lsn_pkg::MUL_Y1:   begin mul_a = dy_q; mul_b = r_qx; end
            default:           begin mul_a = '0;   mul_b = '0;   end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = lsn_pkg::ACC_W'(prod);

    // |D|^2, dot product and cross product accumulation
    always_ff @(posedge i_clk) begin
        case (i_cmd.mul_op)
            lsn_pkg::MUL_DEN0: r_den <= prod[lsn_pkg::DEN_W-1:0];
            lsn_pkg::MUL_DEN1: r_den <= r_den + prod[lsn_pkg::DEN_W-1:0];
            lsn_pkg::MUL_X0:   r_nx  <= prod_ext;
            lsn_pkg::MUL_X1:   r_nx  <= r_nx + prod_ext;
            lsn_pkg::MUL_Y0:   r_ny  <= prod_ext;
            lsn_pkg::MUL_Y1:   r_ny  <= r_ny - prod_ext;
            default:           ;
        endcase
    end

    // Magnitudes for sign-magnitude division
    assign mag_x = r_nx[lsn_pkg::ACC_W-1] ? lsn_pkg::MAG_W'(-r_nx)
                                           : r_nx[lsn_pkg::MAG_W-1:0];
    assign mag_y = r_ny[lsn_pkg::ACC_W-1] ? lsn_pkg::MAG_W'(-r_ny)
                                           : r_ny[lsn_pkg::MAG_W-1:0];
    assign ge_x  = (r_rx >= r_dv);
    assign ge_y  = (r_ry >= r_dv);

    // Dividers: first step checks overflow against |D|^2 << 16,
    // then one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_rx    <= {1'b0, mag_x, {lsn_pkg::FRAC_BITS{1'b0}}}
                       + lsn_pkg::REM_W'(r_den[lsn_pkg::DEN_W-1:1]);
            r_ry    <= {1'b0, mag_y, {lsn_pkg::FRAC_BITS{1'b0}}}
                       + lsn_pkg::REM_W'(r_den[lsn_pkg::DEN_W-1:1]);
            r_dv    <= {r_den, {lsn_pkg::QUO_W{1'b0}}};
            r_neg_x <= r_nx[lsn_pkg::ACC_W-1];
            r_neg_y <= r_ny[lsn_pkg::ACC_W-1];
            r_step  <= '0;
        end else if (i_cmd.div_step) begin
            if (r_step == '0) begin
                r_ovf_x <= ge_x;
                r_ovf_y <= ge_y;
            end else begin
                if (ge_x) r_rx <= r_rx - r_dv;
                if (ge_y) r_ry <= r_ry - r_dv;
                r_quo_x <= {r_quo_x[lsn_pkg::QUO_W-2:0], ge_x};
                r_quo_y <= {r_quo_y[lsn_pkg::QUO_W-2:0], ge_y};
            end
            r_dv   <= r_dv >> 1;
            r_step <= r_step + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_norm.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && out_free) begin
            r_out_x     <= degen ? '0 : lsn_pkg::sat_q412(r_neg_x, r_ovf_x, r_quo_x);
            r_out_y     <= degen ? '0 : lsn_pkg::sat_q412(r_neg_y, r_ovf_y, r_quo_y);
            r_out_last  <= (r_idx == LAST_IDX);
            r_out_degen <= degen;
        end
    end

    assign o_norm.valid      = r_out_valid;
    assign o_norm.norm_x     = r_out_x;
    assign o_norm.norm_y     = r_out_y;
    assign o_norm.is_last    = r_out_last;
    assign o_norm.degenerate = r_out_degen;

    // Status to the controller
    assign o_stat.load_last = in_acc && (r_load_cnt == LAST_IDX);
    assign o_stat.degen     = degen;
    assign o_stat.div_done  = (r_step == STEP_LAST);
    assign o_stat.out_free  = out_free;
    assign o_stat.idx_last  = (r_idx == LAST_IDX);

    // Degenerate shapes carry zero coordinates
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_degen) |-> (r_out_x == '0 && r_out_y == '0))
        else $error("degenerate item with nonzero coordinates");

    // Last point of a shape wraps the load counter
    a_load_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_load_cnt == LAST_IDX) |=> (r_load_cnt == '0))
        else $error("load counter did not wrap at shape end");

    // Emitting the last point ends the shape and the index wraps
    a_emit_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && out_free && r_idx == LAST_IDX) |=> (r_idx == '0 && r_out_last))
        else $error("emit index did not wrap on last point");
endmodule

>>> design/landmark_shape_normalizer.sv
// Landmark shape normalizer: points enter one per cycle while loading; when
// the last point of a shape is taken, the block computes |p6-p0|^2 and then
// handles one point at a time (store read, q terms, four multiply-accumulate
// steps on one shared multiplier, setup, 17 divider steps, emit), the
// restoring dividers giving one quotient bit per cycle. When points 0 and 6
// coincide the arithmetic is skipped and each point goes through only the
// store read, q terms and emit. New points are refused from the end of
// loading through the emit pass and accepted again right after the last
// result enters the output register.
// Depends on lsn_pkg, lsn_if, lsn_ctrl and lsn_datapath.
module landmark_shape_normalizer #(
    parameter int NUM_POINTS = lsn_pkg::NUM_POINTS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    lsn_point_if.sink  i_point,
    lsn_norm_if.source o_norm
);
    lsn_pkg::t_dp_cmd  cmd;
    lsn_pkg::t_dp_stat stat;

    // Sequencer
    lsn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Arithmetic, storage and channel registers
    lsn_datapath #(
        .NUM_POINTS (NUM_POINTS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (i_point),
        .o_norm  (o_norm),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );
endmodule
